>>> hw/rtl/sal2pwm_pkg.sv
package sal2pwm_pkg;

  localparam int unsigned LINE_CAPACITY = 20;
  localparam int unsigned ANGLE_SLOTS   = 4;

  localparam int unsigned ANGLE_MAX   = 180;
  localparam int unsigned WIDE_BASE   = 71;
  localparam int unsigned WIDE_TOP    = 312;
  localparam int unsigned NARROW_BASE = 2;
  localparam int unsigned NARROW_TOP  = 50;
  localparam int unsigned RADIX       = 10;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ACC_W    = 16;
  localparam int unsigned ANGLE_W  = 8;
  localparam int unsigned WIDE_W   = 9;
  localparam int unsigned NARROW_W = 6;
  localparam int unsigned CNT_W    = $clog2(LINE_CAPACITY);
  localparam int unsigned FOUND_W  = $clog2(ANGLE_SLOTS + 1);
  localparam int unsigned LUT_N    = 2 ** ANGLE_W;

  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef logic [WIDE_W-1:0]   wide_lut_t   [LUT_N];
  typedef logic [NARROW_W-1:0] narrow_lut_t [LUT_N];

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
  } in_stage_t;

  function automatic wide_lut_t build_wide_lut();
    wide_lut_t   t;
    int unsigned a;
    for (int unsigned i = 0; i < LUT_N; i++) begin
      a = (i > ANGLE_MAX) ? ANGLE_MAX : i;
      t[i] = WIDE_W'(WIDE_BASE + (a * (WIDE_TOP - WIDE_BASE)) / ANGLE_MAX);
    end
    return t;
  endfunction

  function automatic narrow_lut_t build_narrow_lut();
    narrow_lut_t t;
    int unsigned a;
    for (int unsigned i = 0; i < LUT_N; i++) begin
      a = (i > ANGLE_MAX) ? ANGLE_MAX : i;
      t[i] = NARROW_W'(NARROW_BASE + (a * (NARROW_TOP - NARROW_BASE)) / ANGLE_MAX);
    end
    return t;
  endfunction

  localparam wide_lut_t   WIDE_LUT   = build_wide_lut();
  localparam narrow_lut_t NARROW_LUT = build_narrow_lut();

endpackage

>>> hw/rtl/sal2pwm_in_reg.sv
module sal2pwm_in_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_valid_i,
  output logic                          rx_stall_o,
  input  logic [sal2pwm_pkg::CHAR_W-1:0] rx_char_i,
  input  logic                          take_i,
  output sal2pwm_pkg::in_stage_t        stage_o
);
  import sal2pwm_pkg::*;

  logic              valid_q;
  logic [CHAR_W-1:0] char_q;

  assign rx_stall_o = valid_q && !take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!rx_stall_o) begin
      valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!rx_stall_o && rx_valid_i) begin
      char_q <= rx_char_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.ch    = char_q;

endmodule

>>> hw/rtl/sal2pwm_parser.sv
module sal2pwm_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  sal2pwm_pkg::in_stage_t          stage_i,
  output logic                            take_o,
  output logic                            pos_valid_o,
  input  logic                            pos_stall_i,
  output logic [sal2pwm_pkg::WIDE_W-1:0]   pos_wide_a_o,
  output logic [sal2pwm_pkg::WIDE_W-1:0]   pos_wide_b_o,
  output logic [sal2pwm_pkg::NARROW_W-1:0] pos_narrow_a_o,
  output logic [sal2pwm_pkg::NARROW_W-1:0] pos_narrow_b_o,
  output logic                            applied_o
);
  import sal2pwm_pkg::*;

  logic                mode_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [FOUND_W-1:0]  found_q, found_d;
  logic [ANGLE_W-1:0]  store_q [ANGLE_SLOTS];
  logic [ANGLE_W-1:0]  store_d [ANGLE_SLOTS];
  logic [WIDE_W-1:0]   wide_a_q, wide_b_q;
  logic [NARROW_W-1:0] narrow_a_q, narrow_b_q;
  logic                applied_q;
  logic                out_valid_q, out_valid_d;

  logic                is_eol, is_digit, is_sep;
  logic                active, eol_now, end_val, apply;
  logic [ANGLE_W-1:0]  clamped;
  logic [ANGLE_W-1:0]  slot_ang [4];

  assign is_eol   = (stage_i.ch == CH_LF) || (stage_i.ch == CH_CR);
  assign is_digit = (stage_i.ch >= CH_ZERO) && (stage_i.ch <= CH_NINE);
  assign is_sep   = (stage_i.ch == CH_COMMA) || (stage_i.ch == CH_NUL);

  assign take_o  = !(mode_q && is_eol && out_valid_q && pos_stall_i);
  assign active  = stage_i.valid && take_o && mode_q;
  assign eol_now = active && is_eol;

  assign clamped = (acc_q > ACC_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : acc_q[ANGLE_W-1:0];

  always_comb begin
    count_d = count_q;
    acc_d   = acc_q;
    found_d = found_q;
    end_val = 1'b0;
    for (int k = 0; k < ANGLE_SLOTS; k++) begin
      store_d[k] = store_q[k];
    end
    if (active) begin
      if (is_eol) begin
        end_val = 1'b1;
      end else if (count_q < CNT_W'(LINE_CAPACITY - 1)) begin
        count_d = count_q + CNT_W'(1);
        if (is_digit) begin
          acc_d = ACC_W'({acc_q, 3'b000} + {acc_q, 1'b0} + ACC_W'(stage_i.ch - CH_ZERO));
        end else if (is_sep) begin
          end_val = 1'b1;
        end
      end
    end
    if (end_val && (found_q < FOUND_W'(ANGLE_SLOTS))) begin
      for (int k = 0; k < ANGLE_SLOTS; k++) begin
        if (found_q == FOUND_W'(k)) begin
          store_d[k] = clamped;
        end
      end
      found_d = found_q + FOUND_W'(1);
      acc_d   = '0;
    end
    apply = eol_now && (found_d == FOUND_W'(ANGLE_SLOTS));
    if (eol_now) begin
      count_d = '0;
      acc_d   = '0;
      found_d = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      slot_ang[k] = '0;
      if (k < ANGLE_SLOTS) begin
        slot_ang[k] = store_d[k];
      end
    end
  end

  assign out_valid_d = (out_valid_q && pos_stall_i) || eol_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      count_q     <= '0;
      acc_q       <= '0;
      found_q     <= '0;
      out_valid_q <= 1'b0;
      applied_q   <= 1'b0;
      wide_a_q    <= '0;
      wide_b_q    <= '0;
      narrow_a_q  <= '0;
      narrow_b_q  <= '0;
      for (int k = 0; k < ANGLE_SLOTS; k++) begin
        store_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      acc_q       <= acc_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      for (int k = 0; k < ANGLE_SLOTS; k++) begin
        store_q[k] <= store_d[k];
      end
      if (eol_now) begin
        applied_q <= apply;
      end
      if (apply) begin
        wide_a_q   <= WIDE_LUT[slot_ang[0]];
        wide_b_q   <= WIDE_LUT[slot_ang[1]];
        narrow_a_q <= NARROW_LUT[slot_ang[2]];
        narrow_b_q <= NARROW_LUT[slot_ang[3]];
      end
    end
  end

  assign pos_valid_o    = out_valid_q;
  assign pos_wide_a_o   = wide_a_q;
  assign pos_wide_b_o   = wide_b_q;
  assign pos_narrow_a_o = narrow_a_q;
  assign pos_narrow_b_o = narrow_b_q;
  assign applied_o      = applied_q;

endmodule

>>> hw/rtl/serial_angle_list_to_servo_pwm_core.sv
// Parses lines of comma- or NUL-separated decimal angles from a serial
// receiver into four held servo compare values while serial mode is on;
// otherwise characters are taken and ignored. Throughput is one character
// transfer per clock while no line end waits on a stalled result; a
// character passes an input register and then updates the parser state.
// A CR or LF loads the result register at the edge where it leaves the
// input register; that result transfer carries the held compare values
// and an applied flag. Only line-end characters wait on a stalled result;
// later characters queue behind them. Angle to compare conversion uses
// constant lookup tables, so there is no multi-cycle unit.
module serial_angle_list_to_servo_pwm_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            rx_valid_i,
  output logic                            rx_stall_o,
  input  logic [sal2pwm_pkg::CHAR_W-1:0]   rx_char_i,
  output logic                            pos_valid_o,
  input  logic                            pos_stall_i,
  output logic [sal2pwm_pkg::WIDE_W-1:0]   pos_wide_a_o,
  output logic [sal2pwm_pkg::WIDE_W-1:0]   pos_wide_b_o,
  output logic [sal2pwm_pkg::NARROW_W-1:0] pos_narrow_a_o,
  output logic [sal2pwm_pkg::NARROW_W-1:0] pos_narrow_b_o,
  output logic                            applied_o
);
  import sal2pwm_pkg::*;

  in_stage_t stage;
  logic      take;

  sal2pwm_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_char_i  (rx_char_i),
    .take_i     (take),
    .stage_o    (stage)
  );

  sal2pwm_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .stage_i        (stage),
    .take_o         (take),
    .pos_valid_o    (pos_valid_o),
    .pos_stall_i    (pos_stall_i),
    .pos_wide_a_o   (pos_wide_a_o),
    .pos_wide_b_o   (pos_wide_b_o),
    .pos_narrow_a_o (pos_narrow_a_o),
    .pos_narrow_b_o (pos_narrow_b_o),
    .applied_o      (applied_o)
  );

endmodule

>>> sim/tb_top.sv
module tb_top;
  import sal2pwm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned QUIET_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 175;
  localparam int          PAUSE_MARK   = -1;

  typedef struct packed {
    logic [WIDE_W-1:0]   wide_a;
    logic [WIDE_W-1:0]   wide_b;
    logic [NARROW_W-1:0] narrow_a;
    logic [NARROW_W-1:0] narrow_b;
    logic                applied;
  } servo_pos_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                rx_valid_i  = 1'b0;
  logic                rx_stall_o;
  logic [CHAR_W-1:0]   rx_char_i   = '0;
  logic                pos_valid_o;
  logic                pos_stall_i = 1'b0;
  logic [WIDE_W-1:0]   pos_wide_a_o;
  logic [WIDE_W-1:0]   pos_wide_b_o;
  logic [NARROW_W-1:0] pos_narrow_a_o;
  logic [NARROW_W-1:0] pos_narrow_b_o;
  logic                applied_o;

  serial_angle_list_to_servo_pwm_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_valid_i     (rx_valid_i),
    .rx_stall_o     (rx_stall_o),
    .rx_char_i      (rx_char_i),
    .pos_valid_o    (pos_valid_o),
    .pos_stall_i    (pos_stall_i),
    .pos_wide_a_o   (pos_wide_a_o),
    .pos_wide_b_o   (pos_wide_b_o),
    .pos_narrow_a_o (pos_narrow_a_o),
    .pos_narrow_b_o (pos_narrow_b_o),
    .applied_o      (applied_o)
  );

  // parser mirror
  bit                 serial_on;
  int unsigned        kept_chars;
  logic [ACC_W-1:0]   acc;
  int unsigned        n_angles;
  logic [ANGLE_W-1:0] angle_q [ANGLE_SLOTS];
  logic [WIDE_W-1:0]  held [4];

  servo_pos_t  pending_pos [$];
  int          rx_backlog [$];
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit          burst_req;
  bit          burst_used;
  int unsigned burst_left;
  int unsigned errors;
  int unsigned chars_taken;
  int unsigned results_seen;
  int unsigned applied_seen;
  int unsigned stim_count;
  int unsigned cycle_cnt;

  function automatic logic [WIDE_W-1:0] servo_wide(int unsigned a);
    return WIDE_W'(WIDE_BASE + (a * (WIDE_TOP - WIDE_BASE)) / ANGLE_MAX);
  endfunction

  function automatic logic [NARROW_W-1:0] servo_narrow(int unsigned a);
    return NARROW_W'(NARROW_BASE + (a * (NARROW_TOP - NARROW_BASE)) / ANGLE_MAX);
  endfunction

  function automatic int unsigned angle_at(int unsigned k);
    if (k < ANGLE_SLOTS) return angle_q[k];
    return 0;
  endfunction

  function automatic void close_value();
    logic [ACC_W-1:0] a;
    if (n_angles < ANGLE_SLOTS) begin
      a = (acc > ANGLE_MAX) ? ACC_W'(ANGLE_MAX) : acc;
      angle_q[n_angles] = a[ANGLE_W-1:0];
      n_angles++;
      acc = '0;
    end
  endfunction

  function automatic void parse_char(logic [CHAR_W-1:0] c);
    servo_pos_t p;
    bit         upd;
    if (!serial_on) return;
    if (c == CH_LF || c == CH_CR) begin
      close_value();
      upd = (n_angles == ANGLE_SLOTS);
      if (upd) begin
        held[0] = servo_wide(angle_at(0));
        held[1] = servo_wide(angle_at(1));
        held[2] = WIDE_W'(servo_narrow(angle_at(2)));
        held[3] = WIDE_W'(servo_narrow(angle_at(3)));
      end
      kept_chars = 0;
      acc        = '0;
      n_angles   = 0;
      p.wide_a   = held[0];
      p.wide_b   = held[1];
      p.narrow_a = held[2][NARROW_W-1:0];
      p.narrow_b = held[3][NARROW_W-1:0];
      p.applied  = upd;
      pending_pos.push_back(p);
    end else if (kept_chars < LINE_CAPACITY - 1) begin
      if (c >= CH_ZERO && c <= CH_NINE) acc = ACC_W'(acc * RADIX + (c - CH_ZERO));
      else if (c == CH_COMMA || c == CH_NUL) close_value();
      kept_chars++;
    end
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // rx driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
    end else begin
      if (rx_valid_i && !rx_stall_o) begin
        parse_char(rx_char_i);
        chars_taken++;
      end
      if (!rx_valid_i || !rx_stall_o) begin
        if (rx_backlog.size() > 0 && rx_backlog[0] == PAUSE_MARK && pending_pos.size() == 0)
          void'(rx_backlog.pop_front());
        if (rx_backlog.size() > 0 && rx_backlog[0] != PAUSE_MARK &&
            $urandom_range(0, 99) >= tx_idle_pct) begin
          rx_valid_i <= 1'b1;
          rx_char_i  <= CHAR_W'(rx_backlog.pop_front());
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    servo_pos_t got;
    servo_pos_t want;
    if (!rst_ni) begin
      pos_stall_i <= 1'b0;
    end else begin
      if (pos_valid_o && !pos_stall_i) begin
        got = '{pos_wide_a_o, pos_wide_b_o, pos_narrow_a_o, pos_narrow_b_o, applied_o};
        if (pending_pos.size() == 0) begin
          $display("%0t unexpected result: wa=%0d wb=%0d na=%0d nb=%0d applied=%0b",
                   $time, got.wide_a, got.wide_b, got.narrow_a, got.narrow_b, got.applied);
          errors++;
        end else begin
          want = pending_pos.pop_front();
          results_seen++;
          if (want.applied) applied_seen++;
          if (got.wide_a !== want.wide_a || got.wide_b !== want.wide_b ||
              got.narrow_a !== want.narrow_a || got.narrow_b !== want.narrow_b ||
              got.applied !== want.applied) begin
            $display("%0t mismatch: expected wa=%0d wb=%0d na=%0d nb=%0d applied=%0b, got wa=%0d wb=%0d na=%0d nb=%0d applied=%0b",
                     $time, want.wide_a, want.wide_b, want.narrow_a, want.narrow_b,
                     want.applied, got.wide_a, got.wide_b, got.narrow_a, got.narrow_b,
                     got.applied);
            errors++;
          end
        end
      end
      if (burst_req && !burst_used) begin
        burst_used = 1'b1;
        burst_left = HOLD_CYCLES;
      end
      if (burst_left > 0) begin
        burst_left--;
        pos_stall_i <= 1'b1;
      end else begin
        pos_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t cycle limit reached, %0d results still expected", $time, pending_pos.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_char(logic [CHAR_W-1:0] c);
    rx_backlog.push_back(int'(c));
    stim_count++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_eol();
    push_char($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  function automatic string angle_text();
    int unsigned r;
    int unsigned edges [6] = '{0, 1, 179, 180, 181, 255};
    r = $urandom_range(0, 99);
    if (r < 3) return "";
    if (r < 60) return $sformatf("%0d", $urandom_range(0, 180));
    if (r < 70) return $sformatf("%0d", edges[$urandom_range(0, 5)]);
    if (r < 85) return $sformatf("%0d", $urandom_range(181, 999));
    if (r < 95) return $sformatf("%0d", $urandom_range(1000, 65535));
    return $sformatf("%0d", $urandom_range(65536, 999999));
  endfunction

  // style: 0 clean, 1 filler before each value, 2 long tail before line end
  task automatic add_line(int unsigned n_vals, bit nul_sep, int unsigned style);
    string filler;
    string tail;
    filler = "#;- xA.";
    tail   = "#;- xA.,0179";
    for (int unsigned v = 0; v < n_vals; v++) begin
      if (v > 0) push_char(nul_sep ? CH_NUL : CH_COMMA);
      if (style == 1)
        repeat ($urandom_range(0, 2)) push_char(filler[$urandom_range(0, filler.len() - 1)]);
      push_text(angle_text());
    end
    if (style == 2)
      repeat ($urandom_range(10, 22)) push_char(tail[$urandom_range(0, tail.len() - 1)]);
    push_eol();
  endtask

  task automatic build_random(int unsigned target);
    int unsigned start;
    int unsigned r;
    start = stim_count;
    while (stim_count - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        add_line(ANGLE_SLOTS, $urandom_range(0, 9) == 0, 0);
      end else if (r < 74) begin
        add_line($urandom_range(0, 7), 1'b0, 0);
      end else if (r < 82) begin
        add_line(ANGLE_SLOTS, 1'b0, 1);
      end else if (r < 89) begin
        add_line(ANGLE_SLOTS, 1'b0, 2);
      end else if (r < 96) begin
        repeat ($urandom_range(1, 20)) push_char(CHAR_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) push_eol();
      end else if (r < 98) begin
        rx_backlog.push_back(PAUSE_MARK);
        add_line(ANGLE_SLOTS, 1'b0, 0);
      end else begin
        push_eol();
      end
    end
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (rx_backlog.size() != 0 || rx_valid_i || pending_pos.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mode(bit v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    serial_on    = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    serial_on  = 1'b0;
    kept_chars = 0;
    acc        = '0;
    n_angles   = 0;
    for (int i = 0; i < ANGLE_SLOTS; i++) angle_q[i] = '0;
    for (int i = 0; i < 4; i++) held[i] = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    burst_req    = 1'b0;
    burst_used   = 1'b0;
    burst_left   = 0;
    errors       = 0;
    chars_taken  = 0;
    results_seen = 0;
    applied_seen = 0;
    stim_count   = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: full-scale angles, empty line, surplus values
    write_mode(1'b1);
    push_text("180,0,99,45");
    push_char(CH_LF);
    push_char(CH_CR);
    push_text("1,2,3,4,5");
    push_char(CH_LF);
    settle();

    // no idling; long output stall with input pressure, then a drain pause
    build_random(PHASE_ITEMS / 2);
    rx_backlog.push_back(PAUSE_MARK);
    build_random(PHASE_ITEMS / 2);
    burst_req = 1'b1;
    settle();

    // serial mode off: everything ignored
    write_mode(1'b0);
    push_text("12,3,4,5");
    push_char(CH_CR);
    push_char(CH_LF);
    repeat (10) push_char(CHAR_W'($urandom_range(0, 255)));
    settle();
    write_mode(1'b1);

    tx_idle_pct  = 61;
    rx_stall_pct = 0;
    build_random(PHASE_ITEMS);
    settle();

    tx_idle_pct  = 0;
    rx_stall_pct = 61;
    build_random(PHASE_ITEMS);
    settle();

    tx_idle_pct  = 6;
    rx_stall_pct = 6;
    build_random(PHASE_ITEMS);
    settle();

    repeat (2 * QUIET_CYCLES) @(posedge clk_i);
    if (pending_pos.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, pending_pos.size());
      errors++;
    end
    $display("Covered %0d rx transfers over five idle/stall phases, a mode-off stretch and a long output hold-off.",
             chars_taken);
    $display("Checked %0d line results (%0d applied new compare values), %0d errors.",
             results_seen, applied_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
